>>> hdl/csvp_pkg.sv
package csvp_pkg;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_DONE = 2'd2
    } t_kind;

    // Front sequencer states
    typedef enum logic [1:0] {
        FS_IDLE,
        FS_FLUSH,
        FS_TAIL
    } t_front_state;

    // Special characters
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // Word queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       line_end;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  field_byte;
        logic [15:0] columns;
        logic        space_overflow;
        logic        last;
    } t_out_item;

    // Queued word: a result without its column count
    typedef struct packed {
        t_kind      kind;
        logic [7:0] field_byte;
        logic       space_overflow;
        logic       last;
    } t_word;

    typedef struct packed {
        logic  push;
        t_word word;
    } t_q_push;

    typedef struct packed {
        logic  avail;
        t_word word;
    } t_q_head;

    function automatic logic is_white(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

endpackage

>>> hdl/csvp_front.sv
module csvp_front
    import csvp_pkg::*;
#(
    parameter int HELD_SPACE_DEPTH = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  logic     i_q_full,
    output t_q_push  o_push
);

    localparam int CW = $clog2(HELD_SPACE_DEPTH + 1);
    localparam int AW = (HELD_SPACE_DEPTH > 1) ? $clog2(HELD_SPACE_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(HELD_SPACE_DEPTH);

    t_front_state r_state, n_state;
    logic r_in_quote, n_in_quote;
    logic r_qseen, n_qseen;
    logic r_quoted, n_quoted;
    logic r_blank, n_blank;
    logic r_nonempty, n_nonempty;
    logic r_finished, n_finished;
    logic r_ovf, n_ovf;
    logic [CW-1:0] r_held, n_held;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_fcnt, n_fcnt;
    t_word r_tail, n_tail;
    logic r_tail_vld, n_tail_vld;
    logic [7:0] r_mem [HELD_SPACE_DEPTH];
    logic [7:0] r_rd_data;
    logic [AW-1:0] rd_addr;

    t_word c_word;
    logic  c_word_vld;
    logic  c_flush;
    logic  c_done_tail;
    logic  c_wr_en;
    logic  c_outside;
    logic  accept;
    logic  flush_end;
    logic [7:0] b;

    assign b       = i_item.text_byte;
    assign o_ready = (r_state == FS_IDLE) && !i_q_full;
    assign accept  = i_valid && o_ready;

    // Classify one input byte against the parser state
    always_comb begin
        n_in_quote  = r_in_quote;
        n_qseen     = r_qseen;
        n_quoted    = r_quoted;
        n_blank     = r_blank;
        n_nonempty  = r_nonempty;
        n_finished  = r_finished;
        n_ovf       = r_ovf;
        n_held      = r_held;
        c_word      = '{kind: KIND_DATA, field_byte: b, space_overflow: r_ovf, last: 1'b1};
        c_word_vld  = 1'b0;
        c_flush     = 1'b0;
        c_done_tail = 1'b0;
        c_wr_en     = 1'b0;
        c_outside   = 1'b0;

        if (i_item.line_end) begin
            if (!r_blank) begin
                c_word      = '{kind: KIND_END, field_byte: 8'd0, space_overflow: r_ovf,
                                last: 1'b0};
                c_done_tail = 1'b1;
            end else begin
                c_word = '{kind: KIND_DONE, field_byte: 8'd0, space_overflow: r_ovf,
                           last: 1'b1};
            end
            c_word_vld = 1'b1;
            n_in_quote = 1'b0;
            n_qseen    = 1'b0;
            n_quoted   = 1'b0;
            n_blank    = 1'b1;
            n_nonempty = 1'b0;
            n_finished = 1'b0;
            n_ovf      = 1'b0;
            n_held     = '0;
        end else if (r_finished) begin
            // drop bytes until line end
        end else if (b == CH_NUL) begin
            n_finished = 1'b1;
        end else if (r_in_quote) begin
            if (r_qseen) begin
                n_qseen = 1'b0;
                if (b == CH_QUOTE) begin
                    c_word_vld = 1'b1;
                    n_nonempty = 1'b1;
                end else begin
                    n_in_quote = 1'b0;
                    c_outside  = 1'b1;
                end
            end else if (b == CH_QUOTE) begin
                n_qseen = 1'b1;
            end else begin
                c_word_vld = 1'b1;
                n_nonempty = 1'b1;
            end
        end else begin
            c_outside = 1'b1;
        end

        if (c_outside) begin
            if ((b == CH_LF) || (b == CH_CR)) begin
                n_finished = 1'b1;
            end else if (b == CH_QUOTE) begin
                n_in_quote = 1'b1;
                n_quoted   = 1'b1;
                n_blank    = 1'b0;
                c_flush    = 1'b1;
                n_held     = '0;
            end else if (!r_nonempty && is_white(b)) begin
                // skip leading whitespace
            end else if (b == CH_COMMA) begin
                n_held     = '0;
                c_word     = '{kind: KIND_END, field_byte: 8'd0, space_overflow: r_ovf,
                               last: 1'b1};
                c_word_vld = 1'b1;
                n_quoted   = 1'b0;
                n_nonempty = 1'b0;
            end else begin
                n_blank = 1'b0;
                if (is_white(b) && !r_quoted) begin
                    if (r_held < DEPTH_C) begin
                        c_wr_en = 1'b1;
                        n_held  = r_held + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end else begin
                    c_flush    = 1'b1;
                    n_held     = '0;
                    c_word_vld = 1'b1;
                    n_nonempty = 1'b1;
                end
            end
        end
    end

    assign flush_end = (CW'(r_idx + 1'b1) == r_fcnt);

    // Sequence the words of one item into the queue
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_fcnt      = r_fcnt;
        n_tail      = r_tail;
        n_tail_vld  = r_tail_vld;
        o_push.push = 1'b0;
        o_push.word = c_word;
        rd_addr     = '0;

        unique case (r_state)
            FS_IDLE: begin
                if (accept) begin
                    if (c_flush && (r_held != '0)) begin
                        n_state    = FS_FLUSH;
                        n_idx      = '0;
                        n_fcnt     = r_held;
                        n_tail     = c_word;
                        n_tail_vld = c_word_vld;
                    end else if (c_word_vld) begin
                        o_push.push = 1'b1;
                        if (c_done_tail) begin
                            n_tail     = '{kind: KIND_DONE, field_byte: 8'd0,
                                           space_overflow: r_ovf, last: 1'b1};
                            n_tail_vld = 1'b1;
                            n_state    = FS_TAIL;
                        end
                    end
                end
            end
            FS_FLUSH: begin
                rd_addr     = r_idx[AW-1:0];
                o_push.word = '{kind: KIND_DATA, field_byte: r_rd_data,
                                space_overflow: r_ovf, last: flush_end && !r_tail_vld};
                if (!i_q_full) begin
                    o_push.push = 1'b1;
                    if (flush_end) begin
                        n_state = r_tail_vld ? FS_TAIL : FS_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        rd_addr = n_idx[AW-1:0];
                    end
                end
            end
            FS_TAIL: begin
                o_push.word = r_tail;
                if (!i_q_full) begin
                    o_push.push = 1'b1;
                    n_tail_vld  = 1'b0;
                    n_state     = FS_IDLE;
                end
            end
            default: n_state = FS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= FS_IDLE;
            r_in_quote <= 1'b0;
            r_qseen    <= 1'b0;
            r_quoted   <= 1'b0;
            r_blank    <= 1'b1;
            r_nonempty <= 1'b0;
            r_finished <= 1'b0;
            r_ovf      <= 1'b0;
            r_held     <= '0;
            r_idx      <= '0;
            r_fcnt     <= '0;
            r_tail_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_fcnt     <= n_fcnt;
            r_tail_vld <= n_tail_vld;
            if (accept) begin
                r_in_quote <= n_in_quote;
                r_qseen    <= n_qseen;
                r_quoted   <= n_quoted;
                r_blank    <= n_blank;
                r_nonempty <= n_nonempty;
                r_finished <= n_finished;
                r_ovf      <= n_ovf;
                r_held     <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tail <= n_tail;
    end

    // Held whitespace store
    always_ff @(posedge i_clk) begin
        if (accept && c_wr_en) begin
            r_mem[r_held[AW-1:0]] <= b;
        end
        r_rd_data <= r_mem[rd_addr];
    end

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= DEPTH_C)
        else $error("held whitespace count past buffer depth");

    a_flush_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FS_FLUSH) |-> ((r_idx < r_fcnt) && (r_held == '0)))
        else $error("flush index out of range or store refilled during flush");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.push |-> !i_q_full)
        else $error("word pushed into full queue");

    a_tail_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FS_TAIL) |-> r_tail_vld)
        else $error("tail state without pending word");
`endif

endmodule

>>> hdl/csvp_queue.sv
module csvp_queue
    import csvp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_push i_push,
    output logic    o_full,
    output t_q_head o_head,
    input  logic    i_pop
);

    t_word         r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;
    logic            do_pop;

    assign o_full       = (r_count == (Q_AW + 1)'(Q_DEPTH));
    assign o_head.avail = (r_count != '0);
    assign o_head.word  = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_head.avail;

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr_ptr] <= i_push.word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push.push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hdl/csvp_back.sv
module csvp_back
    import csvp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_head   i_head,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_result
);

    logic [15:0] r_cols;
    logic        r_out_vld;
    t_out_item   r_out;
    t_out_item   n_out;
    logic [15:0] n_cols;

    assign o_pop    = i_head.avail && (!r_out_vld || i_ready);
    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    // Count field ends; report and clear the count on line done
    always_comb begin
        n_cols               = r_cols;
        n_out.kind           = i_head.word.kind;
        n_out.field_byte     = i_head.word.field_byte;
        n_out.columns        = 16'd0;
        n_out.space_overflow = i_head.word.space_overflow;
        n_out.last           = i_head.word.last;
        unique case (i_head.word.kind)
            KIND_END: begin
                if (r_cols != 16'hFFFF) begin
                    n_cols = r_cols + 1'b1;
                end
            end
            KIND_DONE: begin
                n_out.columns = r_cols;
                n_cols        = 16'd0;
            end
            default: n_cols = r_cols;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols    <= 16'd0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cols    <= n_cols;
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

endmodule

>>> hdl/csv_line_field_parser.sv
// Channel   Direction  Handshake                 Word
// -------   ---------  ------------------------  ---------------------------------
// input     in         i_in_valid / o_in_ready   i_item   (text_byte, line_end)
// result    out        o_out_valid / i_out_ready o_result (kind, field_byte,
//                                                 columns, space_overflow, last)
//
// The front takes an input word only while idle. A byte that releases N held trailing
// whitespace bytes yields N flush words and then its own word, or the flush words alone
// for an opening quote, and a line end that closes a field yields END and then DONE;
// the front emits one word per cycle into its queue while the queue is not full.
// Reset (i_rst_n low at a rising edge) clears the parser, the queue and the
// column counter; the held whitespace store needs no clearing.
// A stalled result side fills the four-word queue, then drops o_in_ready.
module csv_line_field_parser
    import csvp_pkg::*;
#(
    parameter int HELD_SPACE_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_result
);

    // Front to queue: one word per cycle at most
    t_q_push q_push;
    logic    q_full;
    // Queue to back: head word and pop
    t_q_head q_head;
    logic    q_pop;

    // Classify bytes, hold trailing whitespace, sequence flush bursts
    csvp_front #(
        .HELD_SPACE_DEPTH(HELD_SPACE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_item),
        .i_q_full(q_full),
        .o_push  (q_push)
    );

    // Decouple the front from output stalls
    csvp_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .o_full (q_full),
        .o_head (q_head),
        .i_pop  (q_pop)
    );

    // Count columns and drive the registered result word
    csvp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_result(o_result)
    );

endmodule
